// File: rtl/mpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the mouse packet decoder.
// No dependencies; every other file imports this package.
package mpd_pkg;

    localparam int BYTE_W      = 8;
    localparam int DELTA_W     = 9;
    localparam int WHEEL_W     = 2;
    localparam int BTN_W       = 3;
    localparam int PTR_W       = 16;
    localparam int LIMIT_W     = 16;
    localparam int LEN_W       = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    localparam int DEF_MAX_PACKET_BYTES = 8;
    localparam int DEF_POSITION_BITS    = 16;

    localparam int MIN_PACKET_BYTES   = 5;
    // Packets of this length carry the wheel bytes
    localparam int WHEEL_PACKET_BYTES = 8;
    // Highest byte position that decoding ever reads
    localparam int LAST_DECODED_BYTE  = 6;

    localparam logic [BYTE_W-1:0]  SYNC_MASK_RST  = 8'hF8;
    localparam logic [BYTE_W-1:0]  SYNC_VALUE_RST = 8'h80;
    localparam logic [LEN_W-1:0]   PKT_LEN_RST    = 4'd8;
    localparam logic [LIMIT_W-1:0] LIMIT_RST      = 16'hFFFF;

    localparam logic signed [WHEEL_W-1:0] WHEEL_NONE = 2'sd0;
    localparam logic signed [WHEEL_W-1:0] WHEEL_UP   = 2'sd1;
    localparam logic signed [WHEEL_W-1:0] WHEEL_DOWN = -2'sd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SYNC_MASK  = 3'd0,
        REG_SYNC_VALUE = 3'd1,
        REG_PKT_LEN    = 3'd2,
        REG_LIMIT_X    = 3'd3,
        REG_LIMIT_Y    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  sync_mask;
        logic [BYTE_W-1:0]  sync_value;
        logic [LEN_W-1:0]   packet_length;
        logic [LIMIT_W-1:0] limit_x;
        logic [LIMIT_W-1:0] limit_y;
    } cfg_t;

    // One decoded packet, handed from the collector to the update stage
    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [WHEEL_W-1:0] dz;
        logic [BTN_W-1:0]          buttons;
    } frame_t;

endpackage

// File: rtl/mpd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: byte input, decoded result, register write.
// Depends on mpd_pkg.
interface mpd_byte_if import mpd_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface mpd_result_if import mpd_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic [PTR_W-1:0]          pointer_x;
    logic [PTR_W-1:0]          pointer_y;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic signed [WHEEL_W-1:0] wheel_step;
    logic [BTN_W-1:0]          button_state;
    logic                      changed;

    modport source (output valid, output pointer_x, output pointer_y, output delta_x,
                    output delta_y, output wheel_step, output button_state,
                    output changed, input ready);
    modport sink   (input valid, input pointer_x, input pointer_y, input delta_x,
                    input delta_y, input wheel_step, input button_state,
                    input changed, output ready);
endinterface

interface mpd_cfg_if import mpd_pkg::*; ;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/mpd_collector.sv
`timescale 1ns / 1ps
// Sync hunt, packet byte store and decode of a completed packet into a frame.
// Depends on mpd_pkg and mpd_byte_if.
module mpd_collector import mpd_pkg::*; #(
    parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    mpd_byte_if.sink        bytes,
    output logic            frame_valid,
    output frame_t          frame,
    input  logic            frame_take
);

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] store_reg [MAX_PACKET_BYTES];
    logic              frame_valid_reg, frame_valid_next;
    frame_t            frame_reg;
    frame_t            frame_dec;

    logic [LEN_W-1:0]  len_eff;
    logic              accept;
    logic              synced;
    logic              last;
    logic              wheel_en;
    logic [BYTE_W-1:0] pkt_byte [LAST_DECODED_BYTE+1];
    logic signed [DELTA_W-1:0] z;

    // Slot is free, or its frame moves on in this cycle
    assign bytes.ready = !frame_valid_reg || frame_take;
    assign accept      = bytes.valid && bytes.ready;

    always_comb
    begin
        if (cfg.packet_length < LEN_W'(MIN_PACKET_BYTES))
            len_eff = LEN_W'(MIN_PACKET_BYTES);
        else if (cfg.packet_length > LEN_W'(MAX_PACKET_BYTES))
            len_eff = LEN_W'(MAX_PACKET_BYTES);
        else
            len_eff = cfg.packet_length;
    end

    assign synced   = (count_reg != '0) ||
                      ((bytes.data_byte & cfg.sync_mask) == cfg.sync_value);
    // >= so that a length lowered mid-packet still ends the packet
    assign last     = (LEN_W'(count_reg) + LEN_W'(1)) >= len_eff;
    assign wheel_en = len_eff == LEN_W'(WHEEL_PACKET_BYTES);

    // Packet bytes as seen after this byte is stored
    for (genvar k = 0; k <= LAST_DECODED_BYTE; k++)
    begin : g_byte
        if (k < MAX_PACKET_BYTES)
        begin : g_have
            assign pkt_byte[k] = (count_reg == CNT_W'(k)) ? bytes.data_byte : store_reg[k];
        end
        else
        begin : g_none
            assign pkt_byte[k] = '0;
        end
    end

    always_comb
    begin
        frame_dec.dx = DELTA_W'($signed(pkt_byte[1])) + DELTA_W'($signed(pkt_byte[3]));
        frame_dec.dy = DELTA_W'($signed(pkt_byte[2])) + DELTA_W'($signed(pkt_byte[4]));
        z = DELTA_W'($signed(pkt_byte[5])) - DELTA_W'($signed(pkt_byte[6]));
        if (!wheel_en || z == '0)
            frame_dec.dz = WHEEL_NONE;
        else if (z < 0)
            frame_dec.dz = WHEEL_DOWN;
        else
            frame_dec.dz = WHEEL_UP;
        // Button bits are active low: b0 bit2 left, bit1 middle, bit0 right
        frame_dec.buttons = {~pkt_byte[0][0], ~pkt_byte[0][1], ~pkt_byte[0][2]};
    end

    always_comb
    begin
        count_next       = count_reg;
        frame_valid_next = frame_valid_reg && !frame_take;
        if (accept && synced)
        begin
            if (last)
            begin
                count_next       = '0;
                frame_valid_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && synced)
            store_reg[count_reg] <= bytes.data_byte;
        if (accept && synced && last)
            frame_reg <= frame_dec;
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

// File: rtl/mpd_update.sv
`timescale 1ns / 1ps
// Position update with clamping, change detection and the result register.
// Depends on mpd_pkg and mpd_result_if.
module mpd_update import mpd_pkg::*; #(
    parameter int POSITION_BITS = DEF_POSITION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        frame_valid,
    input  frame_t      frame,
    output logic        frame_take,
    mpd_result_if.source results
);

    localparam int LIM_W = (POSITION_BITS > LIMIT_W) ? POSITION_BITS : LIMIT_W;
    localparam int SUM_W = LIM_W + 2;

    logic [POSITION_BITS-1:0] pos_x_reg, pos_x_next;
    logic [POSITION_BITS-1:0] pos_y_reg, pos_y_next;
    logic [BTN_W-1:0]         last_btn_reg;
    logic                     out_valid_reg;

    logic [LIM_W-1:0]         top;
    logic [LIM_W-1:0]         lim_x;
    logic [LIM_W-1:0]         lim_y;
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic                     chg;

    function automatic logic [POSITION_BITS-1:0] clamp_pos(
        input logic signed [SUM_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic [POSITION_BITS-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed(SUM_W'(lim)))
            r = POSITION_BITS'(lim);
        else
            r = POSITION_BITS'(v);
        return r;
    endfunction

    assign frame_take = frame_valid && (!out_valid_reg || results.ready);

    always_comb
    begin
        top   = LIM_W'({POSITION_BITS{1'b1}});
        lim_x = (LIM_W'(cfg.limit_x) < top) ? LIM_W'(cfg.limit_x) : top;
        lim_y = (LIM_W'(cfg.limit_y) < top) ? LIM_W'(cfg.limit_y) : top;
        sum_x = $signed(SUM_W'(pos_x_reg)) + SUM_W'(frame.dx);
        // Screen y grows downward, device y grows upward
        sum_y = $signed(SUM_W'(pos_y_reg)) - SUM_W'(frame.dy);
        pos_x_next = clamp_pos(sum_x, lim_x);
        pos_y_next = clamp_pos(sum_y, lim_y);
        chg = (frame.dx != '0) || (frame.dy != '0) || (frame.dz != WHEEL_NONE) ||
              (frame.buttons != last_btn_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            last_btn_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_take)
            begin
                pos_x_reg    <= pos_x_next;
                pos_y_reg    <= pos_y_next;
                last_btn_reg <= frame.buttons;
            end
            if (frame_take)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            results.pointer_x    <= PTR_W'(pos_x_next);
            results.pointer_y    <= PTR_W'(pos_y_next);
            results.delta_x      <= frame.dx;
            results.delta_y      <= frame.dy;
            results.wheel_step   <= frame.dz;
            results.button_state <= frame.buttons;
            results.changed      <= chg;
        end
    end

    assign results.valid = out_valid_reg;

endmodule

// File: rtl/mouse_packet_decoder_unit.sv
`timescale 1ns / 1ps
// Mouse packet decoder. Takes one byte of a Mouse Systems style stream per
// request on "bytes" and, once per completed packet, returns one request on
// "results" with the clamped pointer position, the summed X/Y deltas, a
// wheel click (-1/0/+1, 8-byte packets only), the active-high button state
// and a changed flag. Outside a packet, bytes whose masked value does not
// equal sync_value are dropped. A byte can be taken every cycle: the
// collector decodes a packet as its last byte arrives and parks it in a
// one-entry frame register, and the update stage moves it into the result
// register, which drives "results.valid".
// Input is stalled only when both the frame and the result registers are
// full. Registers (index: name) are 0 sync_mask, 1 sync_value,
// 2 packet_length (5..8, out-of-range values are clipped), 3 limit_x,
// 4 limit_y; writes are always taken, unknown indexes are ignored, and
// they should only be made while no packet result is outstanding.
// Depends on mpd_pkg, mpd_if, mpd_collector and mpd_update.
module mouse_packet_decoder_unit import mpd_pkg::*; #(
    parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES,
    parameter int POSITION_BITS    = DEF_POSITION_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    mpd_byte_if.sink      bytes,
    mpd_result_if.source  results,
    mpd_cfg_if.sink       cfg
);

    cfg_t   cfg_reg;
    logic   frame_valid;
    frame_t frame;
    logic   frame_take;

    // Register file: writes are always accepted, no read-back
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_mask     <= SYNC_MASK_RST;
            cfg_reg.sync_value    <= SYNC_VALUE_RST;
            cfg_reg.packet_length <= PKT_LEN_RST;
            cfg_reg.limit_x       <= LIMIT_RST;
            cfg_reg.limit_y       <= LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SYNC_MASK:  cfg_reg.sync_mask     <= cfg.data[BYTE_W-1:0];
                REG_SYNC_VALUE: cfg_reg.sync_value    <= cfg.data[BYTE_W-1:0];
                REG_PKT_LEN:    cfg_reg.packet_length <= cfg.data[LEN_W-1:0];
                REG_LIMIT_X:    cfg_reg.limit_x       <= cfg.data[LIMIT_W-1:0];
                REG_LIMIT_Y:    cfg_reg.limit_y       <= cfg.data[LIMIT_W-1:0];
                default:        ; // unused index
            endcase
        end
    end

    // Sync hunt, byte store, packet decode
    mpd_collector #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_collector (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .bytes       (bytes),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_take  (frame_take)
    );

    // Position tracking and result register
    mpd_update #(
        .POSITION_BITS (POSITION_BITS)
    ) u_update (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_take  (frame_take),
        .results     (results)
    );

endmodule

// File: rtl/mpd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the mouse packet decoder, bound to the top level.
// Depends on mpd_pkg and mouse_packet_decoder_unit.
module mpd_checker import mpd_pkg::*; (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [DELTA_W-1:0] delta_x,
    input logic signed [DELTA_W-1:0] delta_y,
    input logic signed [WHEEL_W-1:0] wheel_step,
    input logic                      changed
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Any motion or wheel click must be flagged as a change
    a_changed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (delta_x != '0 || delta_y != '0 || wheel_step != WHEEL_NONE)
        |-> changed)
        else $error("motion without changed flag");

    // Wheel is a single click in either direction
    a_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (wheel_step == WHEEL_NONE || wheel_step == WHEEL_UP ||
                       wheel_step == WHEEL_DOWN))
        else $error("bad wheel code");

    // A fresh result must follow a taken packet byte
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a packet byte");

endmodule

bind mouse_packet_decoder_unit mpd_checker u_mpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (bytes.valid),
    .in_ready   (bytes.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .delta_x    (results.delta_x),
    .delta_y    (results.delta_y),
    .wheel_step (results.wheel_step),
    .changed    (results.changed)
);
